// ===== rtl/ppc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppc_pkg
// Shared types and constants of the packet pad-and-chaff framer.
// ----------------------------------------------------------------------------
package ppc_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_PAD_ENABLE   = 3'd0;
    localparam logic [2:0] REG_CHAFF_ENABLE = 3'd1;
    localparam logic [2:0] REG_TARGET_LEN   = 3'd2;
    localparam logic [2:0] REG_ALIGN_SIZE   = 3'd3;
    localparam logic [2:0] REG_LFSR_SEED    = 3'd4;

    // Reset values of the configuration registers
    localparam logic        PAD_ENABLE_RST   = 1'b1;
    localparam logic        CHAFF_ENABLE_RST = 1'b1;
    localparam logic [11:0] TARGET_LEN_RST   = 12'd1500;
    localparam logic [11:0] ALIGN_SIZE_RST   = 12'd16;
    localparam logic [31:0] SEED_RESET       = 32'h1234_5678;
    localparam logic [31:0] LFSR_ZERO_FIX    = 32'h1ACE_B00C;

    // Output byte kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_PAD     = 2'd1;
    localparam logic [1:0] KIND_CHAFF   = 2'd2;

    // Word queue between front and back end
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_DATA,
        OP_DATA_LAST,
        OP_FILL
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
    } cmd_t;

    typedef enum logic [1:0] {
        TAIL_IDLE,
        TAIL_PAD,
        TAIL_CHAFF
    } tail_t;

    typedef struct packed {
        logic        pad_enable;
        logic        chaff_enable;
        logic [11:0] target_length;
        logic [11:0] align_size;
    } cfg_t;

    // Fibonacci LFSR, taps 0,2,3,5, shifting right; all-zero state is fixed up
    function automatic logic [31:0] lfsr_step(input logic [31:0] s);
        logic [31:0] v;
        logic        fb;
        v  = (s == 32'd0) ? LFSR_ZERO_FIX : s;
        fb = v[0] ^ v[2] ^ v[3] ^ v[5];
        return {fb, v[31:1]};
    endfunction

endpackage

// ===== rtl/ppc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppc_front
// Accepts input words, classifies them into payload, last payload or fill
// tick, and holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module ppc_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] in_byte
    input  logic [0:0]         s_tuser,   // [0] req_type
    input  logic               s_tlast,
    output logic               q_valid,
    input  logic               q_ready,
    output ppc_pkg::cmd_t      q_cmd
);

    ppc_pkg::cmd_t                queue_reg [ppc_pkg::QUEUE_DEPTH];
    logic [ppc_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [ppc_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [ppc_pkg::QCNT_W-1:0]   count_reg, count_next;
    ppc_pkg::cmd_t                in_cmd;
    logic                         push;
    logic                         pop;

    always_comb begin
        in_cmd.data = s_tdata;
        if (s_tuser[0]) begin
            in_cmd.op = ppc_pkg::OP_FILL;
        end else if (s_tlast) begin
            in_cmd.op = ppc_pkg::OP_DATA_LAST;
        end else begin
            in_cmd.op = ppc_pkg::OP_DATA;
        end
    end

    assign s_tready = (count_reg != ppc_pkg::QCNT_W'(ppc_pkg::QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_cmd    = queue_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + ppc_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + ppc_pkg::QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + ppc_pkg::QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - ppc_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// ===== rtl/ppc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppc_back
// Frame state machine: passes payload, computes the padded length on the
// last payload word, emits pad and chaff words on fill ticks. Results go
// to an output register.
// ----------------------------------------------------------------------------
module ppc_back #(
    parameter int MAX_FRAME_BYTES = 2048
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  ppc_pkg::cfg_t      cfg,
    input  logic               seed_load,
    input  logic [31:0]        seed_value,
    input  logic               q_valid,
    output logic               q_ready,
    input  ppc_pkg::cmd_t      q_cmd,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,
    output logic [1:0]         m_tuser,
    output logic               m_tlast
);

    // Position must hold the payload cap and any 12-bit tail length
    localparam int POS_MAX = (MAX_FRAME_BYTES > 4095) ? MAX_FRAME_BYTES : 4095;
    localparam int POS_W   = $clog2(POS_MAX + 1);

    ppc_pkg::tail_t     mode_reg, mode_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [11:0]        phase_reg, phase_next;
    logic [11:0]        pad_end_reg, pad_end_next;
    logic [31:0]        lfsr_reg, lfsr_next;
    logic               out_valid_reg, out_valid_next;
    logic [7:0]         out_byte_reg;
    logic [1:0]         out_kind_reg;
    logic               out_end_reg;

    logic               pop;
    logic               is_fill;
    logic               is_last;
    logic               in_tail;
    logic [POS_W-1:0]   base_pos;
    logic [11:0]        base_phase;
    logic               overflow;
    logic [12:0]        phase_inc;
    logic [11:0]        phase_wrap;
    logic [POS_W-1:0]   len;
    logic [11:0]        ph;
    logic [11:0]        gap;
    logic [POS_W:0]     len_x;
    logic [POS_W:0]     target_x;
    logic [POS_W:0]     round_up;
    logic [POS_W:0]     padded_a;
    logic [POS_W:0]     padded_b;
    logic [POS_W:0]     padded;
    logic               finish_pad;
    logic               finish_chaff;
    logic               finish_end;
    logic [POS_W-1:0]   pos_tick;
    logic               pad_done;
    logic               pad_to_chaff;
    logic               chaff_done;
    logic [31:0]        lfsr_stepped;

    logic               res_valid;
    logic [7:0]         res_byte;
    logic [1:0]         res_kind;
    logic               res_end;

    assign q_ready = !out_valid_reg || m_tready;
    assign pop     = q_valid && q_ready;
    assign is_fill = (q_cmd.op == ppc_pkg::OP_FILL);
    assign is_last = (q_cmd.op == ppc_pkg::OP_DATA_LAST);
    assign in_tail = (mode_reg != ppc_pkg::TAIL_IDLE);

    // Payload word: a word during a tail starts a fresh packet
    assign base_pos   = in_tail ? '0 : pos_reg;
    assign base_phase = in_tail ? '0 : phase_reg;
    assign overflow   = (base_pos >= POS_W'(MAX_FRAME_BYTES));
    assign phase_inc  = {1'b0, base_phase} + 13'd1;
    assign phase_wrap = (phase_inc >= {1'b0, cfg.align_size}) ? 12'd0 : phase_inc[11:0];
    assign len        = overflow ? base_pos : base_pos + POS_W'(1);
    assign ph         = overflow ? base_phase : phase_wrap;

    // Padded length: with pad_enable, round up to align_size, clamp to target, never below len
    assign gap      = cfg.align_size - ph;
    assign len_x    = (POS_W+1)'(len);
    assign target_x = (POS_W+1)'(cfg.target_length);
    assign round_up = len_x + (POS_W+1)'(gap);
    assign padded_a = (cfg.pad_enable && ph != 12'd0 && cfg.align_size > ph) ? round_up : len_x;
    assign padded_b = (cfg.pad_enable && padded_a > target_x) ? target_x : padded_a;
    assign padded   = (cfg.pad_enable && padded_b < len_x) ? len_x : padded_b;

    assign finish_pad   = (padded > len_x);
    assign finish_chaff = !finish_pad && cfg.chaff_enable && (padded < target_x);
    assign finish_end   = !finish_pad && !finish_chaff;

    // Fill tick
    assign pos_tick     = pos_reg + POS_W'(1);
    assign pad_done     = (pos_tick >= POS_W'(pad_end_reg));
    assign pad_to_chaff = cfg.chaff_enable && (pad_end_reg < cfg.target_length);
    assign chaff_done   = (pos_tick >= POS_W'(cfg.target_length));
    assign lfsr_stepped = ppc_pkg::lfsr_step(lfsr_reg);

    // Next state
    always_comb begin
        mode_next    = mode_reg;
        pos_next     = pos_reg;
        phase_next   = phase_reg;
        pad_end_next = pad_end_reg;
        if (pop) begin
            case (q_cmd.op)
                ppc_pkg::OP_DATA, ppc_pkg::OP_DATA_LAST: begin
                    pos_next   = len;
                    phase_next = ph;
                    mode_next  = ppc_pkg::TAIL_IDLE;
                    if (is_last) begin
                        pad_end_next = padded[11:0];
                        if (finish_pad) begin
                            mode_next = ppc_pkg::TAIL_PAD;
                        end else if (finish_chaff) begin
                            mode_next = ppc_pkg::TAIL_CHAFF;
                        end else begin
                            pos_next     = '0;
                            phase_next   = '0;
                            pad_end_next = '0;
                        end
                    end
                end
                ppc_pkg::OP_FILL: begin
                    case (mode_reg)
                        ppc_pkg::TAIL_PAD: begin
                            pos_next = pos_tick;
                            if (pad_done) begin
                                if (pad_to_chaff) begin
                                    mode_next = ppc_pkg::TAIL_CHAFF;
                                end else begin
                                    mode_next    = ppc_pkg::TAIL_IDLE;
                                    pos_next     = '0;
                                    phase_next   = '0;
                                    pad_end_next = '0;
                                end
                            end
                        end
                        ppc_pkg::TAIL_CHAFF: begin
                            pos_next = pos_tick;
                            if (chaff_done) begin
                                mode_next    = ppc_pkg::TAIL_IDLE;
                                pos_next     = '0;
                                phase_next   = '0;
                                pad_end_next = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (seed_load) begin
            lfsr_next = seed_value;
        end else if (pop && is_fill && mode_reg == ppc_pkg::TAIL_CHAFF) begin
            lfsr_next = lfsr_stepped;
        end else begin
            lfsr_next = lfsr_reg;
        end
    end

    // Outputs
    always_comb begin
        res_valid = 1'b0;
        res_byte  = 8'd0;
        res_kind  = ppc_pkg::KIND_PAYLOAD;
        res_end   = 1'b0;
        case (q_cmd.op)
            ppc_pkg::OP_DATA, ppc_pkg::OP_DATA_LAST: begin
                res_valid = !overflow;
                res_byte  = q_cmd.data;
                res_end   = is_last && finish_end;
            end
            ppc_pkg::OP_FILL: begin
                case (mode_reg)
                    ppc_pkg::TAIL_PAD: begin
                        res_valid = 1'b1;
                        res_kind  = ppc_pkg::KIND_PAD;
                        res_end   = pad_done && !pad_to_chaff;
                    end
                    ppc_pkg::TAIL_CHAFF: begin
                        res_valid = 1'b1;
                        res_byte  = lfsr_stepped[7:0];
                        res_kind  = ppc_pkg::KIND_CHAFF;
                        res_end   = chaff_done;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        if (pop) begin
            out_valid_next = res_valid;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= ppc_pkg::TAIL_IDLE;
            pos_reg       <= '0;
            phase_reg     <= '0;
            pad_end_reg   <= '0;
            lfsr_reg      <= ppc_pkg::SEED_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            mode_reg      <= mode_next;
            pos_reg       <= pos_next;
            phase_reg     <= phase_next;
            pad_end_reg   <= pad_end_next;
            lfsr_reg      <= lfsr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_byte_reg <= res_byte;
            out_kind_reg <= res_kind;
            out_end_reg  <= res_end;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_end_reg;

endmodule

// ===== rtl/packet_pad_and_chaff.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_pad_and_chaff
// Payload pass-through with zero padding to an alignment size and LFSR
// chaff up to a target frame length.
// ----------------------------------------------------------------------------
// Takes one word per clock and gives one word per clock while m_tready is
// high, sustained. An accepted word passes the four-word input queue and
// then the output register before it shows on m_tvalid. The frame state
// (position, alignment phase, tail mode, LFSR) is updated once per word in
// the back end, which sets the one-word-per-cycle rate; the queue lets the
// input keep flowing while m_tready is low until it fills. Payload words send
// through with tuser 0; the last payload word closes the packet and fill
// ticks (s_tuser = 1) then draw zero pad words (tuser 1) and chaff words
// (tuser 2). m_tlast marks the frame's final word. Fill ticks outside a tail
// and payload beyond MAX_FRAME_BYTES produce nothing. Configuration is to be
// written only while no words are in flight.
// ----------------------------------------------------------------------------
module packet_pad_and_chaff #(
    parameter int MAX_FRAME_BYTES = 2048
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic [0:0]  s_tuser,   // [0] req_type
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic [1:0]  m_tuser,   // [1:0] byte_kind
    output logic        m_tlast
);

    logic          pad_enable_reg;
    logic          chaff_enable_reg;
    logic [11:0]   target_length_reg;
    logic [11:0]   align_size_reg;
    logic          seed_load;
    ppc_pkg::cfg_t cfg;
    logic          q_valid;
    logic          q_ready;
    ppc_pkg::cmd_t q_cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pad_enable_reg    <= ppc_pkg::PAD_ENABLE_RST;
            chaff_enable_reg  <= ppc_pkg::CHAFF_ENABLE_RST;
            target_length_reg <= ppc_pkg::TARGET_LEN_RST;
            align_size_reg    <= ppc_pkg::ALIGN_SIZE_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                ppc_pkg::REG_PAD_ENABLE:   pad_enable_reg    <= cfg_wdata[0];
                ppc_pkg::REG_CHAFF_ENABLE: chaff_enable_reg  <= cfg_wdata[0];
                ppc_pkg::REG_TARGET_LEN:   target_length_reg <= cfg_wdata[11:0];
                ppc_pkg::REG_ALIGN_SIZE:   align_size_reg    <= cfg_wdata[11:0];
                default: begin
                end
            endcase
        end
    end

    // The seed register lives in the LFSR itself: a write reloads it
    assign seed_load = cfg_we && (cfg_addr == ppc_pkg::REG_LFSR_SEED);

    always_comb begin
        cfg.pad_enable    = pad_enable_reg;
        cfg.chaff_enable  = chaff_enable_reg;
        cfg.target_length = target_length_reg;
        cfg.align_size    = align_size_reg;
    end

    ppc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_cmd    (q_cmd)
    );

    ppc_back #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .seed_load  (seed_load),
        .seed_value (cfg_wdata),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_cmd      (q_cmd),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

// ===== rtl/ppc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppc_checker
// Port-level checks of the pad-and-chaff framer, bound to the top level.
// ----------------------------------------------------------------------------
module ppc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser,
    input logic       m_tlast
);

    // Stalled output word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("output word changed while stalled");

    // Pad words carry zero data
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ppc_pkg::KIND_PAD |-> m_tdata == 8'd0)
        else $error("pad word with nonzero data");

    // Reset empties the output register
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    // Reset empties the queue, so input is taken at once
    a_reset_in: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready right after reset");

endmodule

bind packet_pad_and_chaff ppc_checker u_ppc_checker (.*);
